/* hw/rtl/block_grown_slot_pool_defines.svh */
// Assertion macros for the slot pool allocator.
// Used by the top level only; no other dependencies.
`ifndef BLOCK_GROWN_SLOT_POOL_DEFINES_SVH
`define BLOCK_GROWN_SLOT_POOL_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define BGSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slot pool check failed");
// next-cycle implication, off during reset
`define BGSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slot pool check failed");
`else
`define BGSP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BGSP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/bgsp_pkg.sv */
// Shared types and constants for the slot pool allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bgsp_pkg;

    localparam int HANDLE_W  = 4;
    localparam int REG_W     = 5;
    localparam int CFG_IDX_W = 8;

    // pool dimensions; each must fit the HANDLE_W-bit handle fields
    localparam int MAX_BLOCKS = 16;
    localparam int MAX_SLOTS  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_BLOCK = 8'd1;
    localparam logic [REG_W-1:0]     REG_RESET           = 5'd16;

    typedef enum logic {
        MODE_TAKE = 1'b0,
        MODE_GIVE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_BLOCK = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_mode                mode;
        logic [HANDLE_W-1:0]  ret_block;
        logic [HANDLE_W-1:0]  ret_slot;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [HANDLE_W-1:0]  got_block;
        logic [HANDLE_W-1:0]  got_slot;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [REG_W-1:0]     wdata;
    } t_cfg;

    // one free-stack entry: a slot handle
    typedef struct packed {
        logic [HANDLE_W-1:0]  blk;
        logic [HANDLE_W-1:0]  slot;
    } t_entry;

endpackage

`default_nettype wire

/* hw/rtl/bgsp_stream_if.sv */
// Valid/ready channel carrying one payload of type T per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bgsp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/block_grown_slot_pool.sv */
// Slot pool allocator top level: sequencer, counters and config registers.
// Depends on bgsp_pkg, bgsp_stream_if, bgsp_stack, block_grown_slot_pool_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "block_grown_slot_pool_defines.svh"

// Slot pool allocator. Each slot is named by a block index and a slot index.
// Free slots sit on a LIFO free stack held in a single-port-write RAM. A take
// (mode 0) pops the top handle; when the stack is empty and fewer than
// block_limit blocks are in use, a new block is opened first and its slots
// 0..n-1 are pushed in ascending order, so slot n-1 comes out first. A
// give-back (mode 1) pushes the handle, answering status 2 when the handle is
// outside the blocks in use and status 3 when the stack already holds every
// slot. Exactly one result per request. A plain take reads the stack, whose
// read has a registered output; a take that opens a block first fills it,
// pushing slots_per_block (clamped) entries at one entry per cycle through
// the RAM write port, and then the take is retried. The request side is
// ready only while the sequencer is idle; a result waiting on the output
// does not hold off the next request. The stack RAM has no reset and needs
// no clearing: only entries below the free count are read.
// Config writes are always taken (ready tied high) and must only happen
// while the block is idle; unknown register indexes are ignored.
module block_grown_slot_pool
    import bgsp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    bgsp_stream_if.sink   i_req,
    bgsp_stream_if.source o_rsp,
    bgsp_stream_if.sink   i_cfg
);

    localparam int DEPTH = MAX_BLOCKS * MAX_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int BU_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ES_W  = $clog2(MAX_SLOTS + 1);
    localparam int PR_W  = BU_W + ES_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_READ,
        S_PUT
    } t_state;

    t_state r_state;

    // config registers
    logic [REG_W-1:0] r_block_limit;
    logic [REG_W-1:0] r_slots_per_block;

    // pool state
    logic [CNT_W-1:0] r_free_count;
    logic [BU_W-1:0]  r_blocks_used;
    logic [ES_W-1:0]  r_fill_idx;

    // latched request, pending and output results
    t_req r_req;
    t_rsp r_res;
    t_rsp r_out;
    logic r_out_valid;

    // derived values
    logic [BU_W-1:0]  eff_limit;
    logic [ES_W-1:0]  eff_slots;
    logic [PR_W-1:0]  capacity;
    logic [CNT_W-1:0] cnt_m1;
    logic             in_fire;
    logic             out_take;
    logic             out_free;
    logic             outside;
    logic             full;
    logic             can_grow;
    logic             fill_last;

    // stack port
    logic             stk_we;
    logic [AW-1:0]    stk_waddr;
    t_entry           stk_wdata;
    logic             stk_re;
    t_entry           stk_rdata;

    // result of this cycle, when fin is set
    logic             fin;
    t_rsp             res;

    assign in_fire  = i_req.valid && i_req.ready;
    assign out_take = o_rsp.valid && o_rsp.ready;
    assign out_free = !r_out_valid || out_take;

    assign i_req.ready   = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // registers above the pool limits act as the limit
    always_comb begin
        if (32'(r_block_limit) > 32'(MAX_BLOCKS)) begin
            eff_limit = BU_W'(MAX_BLOCKS);
        end else begin
            eff_limit = BU_W'(r_block_limit);
        end
        if (32'(r_slots_per_block) > 32'(MAX_SLOTS)) begin
            eff_slots = ES_W'(MAX_SLOTS);
        end else begin
            eff_slots = ES_W'(r_slots_per_block);
        end
    end

    // never above DEPTH since blocks_used <= MAX_BLOCKS
    assign capacity  = PR_W'(r_blocks_used) * PR_W'(eff_slots);
    assign cnt_m1    = r_free_count - CNT_W'(1);
    assign outside   = (32'(r_req.ret_block) >= 32'(r_blocks_used)) ||
                       (32'(r_req.ret_slot) >= 32'(eff_slots));
    assign full      = (32'(r_free_count) >= 32'(capacity));
    assign can_grow  = (r_blocks_used < eff_limit) && (eff_slots != '0);
    assign fill_last = (r_fill_idx == eff_slots - ES_W'(1));

    // stack access: fill pushes, give-back pushes, take pops
    always_comb begin
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_waddr = r_free_count[AW-1:0];
        stk_wdata = '{blk: r_req.ret_block, slot: r_req.ret_slot};
        if (r_state == S_FILL) begin
            stk_we    = 1'b1;
            stk_wdata = '{blk: HANDLE_W'(r_blocks_used), slot: HANDLE_W'(r_fill_idx)};
        end else if (r_state == S_EXEC) begin
            if (r_req.mode == MODE_GIVE) begin
                stk_we = !outside && !full;
            end else begin
                stk_re = (r_free_count != '0);
            end
        end
    end

    bgsp_stack #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (cnt_m1[AW-1:0]),
        .o_rdata (stk_rdata)
    );

    // result selection
    always_comb begin
        fin = 1'b0;
        res = '{status: ST_OK, got_block: '0, got_slot: '0};
        unique case (r_state)
            S_EXEC: begin
                if (r_req.mode == MODE_GIVE) begin
                    fin = 1'b1;
                    if (outside) begin
                        res.status = ST_OUTSIDE;
                    end else if (full) begin
                        res.status = ST_FULL;
                    end
                end else if (r_free_count == '0 && !can_grow) begin
                    fin        = 1'b1;
                    res.status = ST_NO_BLOCK;
                end
            end
            S_READ: begin
                fin           = 1'b1;
                res.got_block = stk_rdata.blk;
                res.got_slot  = stk_rdata.slot;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_free_count  <= '0;
            r_blocks_used <= '0;
        end else begin
            // cleared only when no new result is loaded in the same cycle
            if (out_take && !fin && r_state != S_PUT) begin
                r_out_valid <= 1'b0;
            end
            if (fin) begin
                if (out_free) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end else begin
                    r_res   <= res;
                    r_state <= S_PUT;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_req   <= i_req.payload;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_req.mode == MODE_GIVE) begin
                        if (!outside && !full) begin
                            r_free_count <= r_free_count + CNT_W'(1);
                        end
                    end else if (r_free_count != '0) begin
                        // pop: address count-1 read this edge
                        r_free_count <= cnt_m1;
                        r_state      <= S_READ;
                    end else if (can_grow) begin
                        r_fill_idx <= '0;
                        r_state    <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_free_count <= r_free_count + CNT_W'(1);
                    r_fill_idx   <= r_fill_idx + ES_W'(1);
                    if (fill_last) begin
                        // block complete, retry the take
                        r_blocks_used <= r_blocks_used + BU_W'(1);
                        r_state       <= S_EXEC;
                    end
                end
                S_READ: begin
                    // handled by the result path above
                end
                S_PUT: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_limit     <= REG_RESET;
            r_slots_per_block <= REG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.payload.index)
                CFG_BLOCK_LIMIT:     r_block_limit     <= i_cfg.payload.wdata;
                CFG_SLOTS_PER_BLOCK: r_slots_per_block <= i_cfg.payload.wdata;
                default: begin
                end
            endcase
        end
    end

    // checks
    `BGSP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, 32'(r_free_count) <= 32'(DEPTH))
    `BGSP_ASSERT_IMP(a_blocks_bound, i_clk, i_rst_n, 1'b1, 32'(r_blocks_used) <= 32'(MAX_BLOCKS))
    `BGSP_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, in_fire, r_state != S_IDLE)
    `BGSP_ASSERT_NXT(a_fill_push, i_clk, i_rst_n, r_state == S_FILL, r_free_count == CNT_W'($past(r_free_count) + CNT_W'(1)))

endmodule

`default_nettype wire

/* hw/rtl/bgsp_stack.sv */
// Free-stack storage: one write port, one read port with registered data.
// Depends on bgsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgsp_stack
    import bgsp_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
